FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the nearest delta-R match selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property checked at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication checked at every rising clock edge out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ndrm_pkg.sv
// Types and constants shared by the nearest delta-R match selector
`default_nettype none

package ndrm_pkg;

	localparam int MAX_CANDIDATES = 64;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

	localparam int ETA_W = 17;
	localparam int PHI_W = 16;
	localparam int IDX_W = 6;
	localparam int DIST_W = 35;
	localparam int CUT_W = 18;
	localparam int CUT2_W = 2 * CUT_W;
	localparam int EMAG_W = ETA_W + 1;
	localparam int PMAG_W = PHI_W + 1;
	localparam int ESQ_W = 2 * EMAG_W;
	localparam int PSQ_W = 2 * PMAG_W;

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 48;

	localparam logic [CUT_W-1:0] CUT_RESET = '1;
	localparam logic [CUT2_W-1:0] CUT2_RESET = CUT2_W'(CUT_RESET) * CUT2_W'(CUT_RESET);
	localparam logic [DIST_W-1:0] DIST_NONE = '1;

	typedef struct packed {
		logic [ETA_W-1:0] probe_eta;
		logic [PHI_W-1:0] probe_phi;
		logic [ETA_W-1:0] muon_eta;
		logic [PHI_W-1:0] muon_phi;
		logic             is_combined;
		logic             last_candidate;
	} cand_t;

	typedef struct packed {
		logic              valid;
		logic              combined;
		logic              last;
		logic [DIST_W-1:0] d2;
	} dist_item_t;

	typedef struct packed {
		logic              accepted;
		logic              match_found;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance_sq;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/ndrm_dist.sv
// Input register and squared-distance pipeline (squares, then sum)
`default_nettype none

module ndrm_dist (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  ndrm_pkg::cand_t     in_cand,
	input  wire                 take,
	output ndrm_pkg::dist_item_t item
);

	logic                           v_s1, v_s2, v_s3;
	ndrm_pkg::cand_t                cand_s1;
	logic [ndrm_pkg::ESQ_W-1:0]     esq_s2;
	logic [ndrm_pkg::PSQ_W-1:0]     psq_s2;
	logic                           comb_s2, last_s2;
	logic                           comb_s3, last_s3;
	logic [ndrm_pkg::DIST_W-1:0]    d2_s3;

	logic                           adv1, adv2, adv3;
	logic [ndrm_pkg::EMAG_W-1:0]    deta, emag;
	logic [ndrm_pkg::PHI_W-1:0]     dphi;
	logic [ndrm_pkg::PMAG_W-1:0]    dphi_x, pmag;
	logic [ndrm_pkg::ESQ_W-1:0]     sum;

	assign adv3 = !v_s3 || take;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// eta difference on one extra bit, phi difference wraps on 16 bits
	always_comb begin
		deta = {cand_s1.muon_eta[ndrm_pkg::ETA_W-1], cand_s1.muon_eta}
			- {cand_s1.probe_eta[ndrm_pkg::ETA_W-1], cand_s1.probe_eta};
		emag = deta[ndrm_pkg::EMAG_W-1] ? -deta : deta;
		dphi = cand_s1.muon_phi - cand_s1.probe_phi;
		dphi_x = {dphi[ndrm_pkg::PHI_W-1], dphi};
		pmag = dphi_x[ndrm_pkg::PMAG_W-1] ? -dphi_x : dphi_x;
		sum = esq_s2 + ndrm_pkg::ESQ_W'(psq_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid)
			cand_s1 <= in_cand;
		if (adv2 && v_s1) begin
			esq_s2  <= emag * emag;
			psq_s2  <= pmag * pmag;
			comb_s2 <= cand_s1.is_combined;
			last_s2 <= cand_s1.last_candidate;
		end
		if (adv3 && v_s2) begin
			d2_s3   <= sum[ndrm_pkg::DIST_W-1:0];
			comb_s3 <= comb_s2;
			last_s3 <= last_s2;
		end
	end

	assign item.valid    = v_s3;
	assign item.combined = comb_s3;
	assign item.last     = last_s3;
	assign item.d2       = d2_s3;

endmodule

`default_nettype wire

FILE: rtl/ndrm_acc.sv
// Running minimum over a candidate list and the result register
`default_nettype none

module ndrm_acc (
	input  wire                         clk,
	input  wire                         arst_n,
	input  ndrm_pkg::dist_item_t        item,
	input  wire [ndrm_pkg::CUT2_W-1:0]  cut2,
	output logic                        take,
	output logic                        res_valid,
	input  wire                         res_ready,
	output ndrm_pkg::result_t           res
);

	logic [ndrm_pkg::DIST_W-1:0] min_q;
	logic [ndrm_pkg::IDX_W-1:0]  idx_q;
	logic [ndrm_pkg::CNT_W-1:0]  cnt_q;
	logic                        have_q;
	logic                        res_valid_q;
	ndrm_pkg::result_t           res_q;

	logic                        res_free, in_range, better, new_have, acc;
	logic [ndrm_pkg::DIST_W-1:0] new_min;
	logic [ndrm_pkg::IDX_W-1:0]  new_idx;

	always_comb begin
		res_free = !res_valid_q || res_ready;
		take     = item.valid && (!item.last || res_free);
		in_range = cnt_q < ndrm_pkg::CNT_W'(ndrm_pkg::MAX_CANDIDATES);
		better   = item.combined && in_range && (item.d2 < min_q);
		new_min  = better ? item.d2 : min_q;
		new_idx  = better ? ndrm_pkg::IDX_W'(cnt_q) : idx_q;
		new_have = have_q || better;
		// both cut compares run alongside the minimum compare
		acc = better ? (ndrm_pkg::CUT2_W'(item.d2) <= cut2)
			: (have_q && (ndrm_pkg::CUT2_W'(min_q) <= cut2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= ndrm_pkg::DIST_NONE;
			idx_q       <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take && item.last)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			if (take) begin
				if (item.last) begin
					min_q  <= ndrm_pkg::DIST_NONE;
					idx_q  <= '0;
					cnt_q  <= '0;
					have_q <= 1'b0;
				end else begin
					min_q  <= new_min;
					idx_q  <= new_idx;
					have_q <= new_have;
					if (in_range)
						cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last) begin
			res_q.accepted         <= acc;
			res_q.match_found      <= new_have;
			res_q.best_index       <= new_have ? new_idx : '0;
			res_q.best_distance_sq <= new_have ? new_min : ndrm_pkg::DIST_NONE;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: rtl/nearest_delta_r_match_select_core.sv
// Top level of the nearest delta-R match selector
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata, s_tuser (is_combined), s_tlast (last_candidate)
//  m_       out  m_tvalid/m_tready  m_tdata, one request per closed list
//  cfg_     in   cfg_valid/cfg_ready cfg_data = delta_r_cut
//
// One candidate per cycle sustained unless a list-closing request meets a result still held on m_; a result
// is offered on m_ after the input register, squares, sum, minimum and result register.
// arst_n clears the pipeline and result valids and sets the running minimum and delta_r_cut to all ones.
// s_tready drops only when a list-closing request meets a result still held on m_.
// The squared cut is registered from the registered delta_r_cut after a configuration write.
`default_nettype none

module nearest_delta_r_match_select_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// [16:0] probe_eta, [32:17] probe_phi, [49:33] muon_eta, [65:50] muon_phi, rest zero
	input  wire  [ndrm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] is_combined
	input  wire  [0:0]                         s_tuser,
	input  wire                                s_tlast,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [0] accepted, [1] match_found, [7:2] best_index, [42:8] best_distance_sq, rest zero
	output logic [ndrm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [ndrm_pkg::CUT_W-1:0]         cfg_data
);

	`include "assert_macros.svh"

	logic [ndrm_pkg::CUT_W-1:0]  cut_q;
	logic [ndrm_pkg::CUT2_W-1:0] cut2_q;
	ndrm_pkg::cand_t             cand;
	ndrm_pkg::dist_item_t        item;
	ndrm_pkg::result_t           res;
	logic                        take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q  <= ndrm_pkg::CUT_RESET;
			cut2_q <= ndrm_pkg::CUT2_RESET;
		end else begin
			if (cfg_valid && cfg_ready)
				cut_q <= cfg_data;
			cut2_q <= cut_q * cut_q;
		end
	end

	always_comb begin
		cand.probe_eta      = s_tdata[16:0];
		cand.probe_phi      = s_tdata[32:17];
		cand.muon_eta       = s_tdata[49:33];
		cand.muon_phi       = s_tdata[65:50];
		cand.is_combined    = s_tuser[0];
		cand.last_candidate = s_tlast;
	end

	ndrm_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cand  (cand),
		.take     (take),
		.item     (item)
	);

	ndrm_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cut2      (cut2_q),
		.take      (take),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {5'd0, res.best_distance_sq, res.best_index, res.match_found, res.accepted};

	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready,
		"input stalled without a held result")
	`ASSERT_IMPLIES(a_acc_needs_match, clk, arst_n, m_tvalid && res.accepted, res.match_found,
		"accepted without a match")
	`ASSERT_IMPLIES(a_no_match_fields, clk, arst_n, m_tvalid && !res.match_found,
		(res.best_index == '0) && (res.best_distance_sq == ndrm_pkg::DIST_NONE),
		"empty result fields not cleared")

endmodule

`default_nettype wire

FILE: test/tb_nearest_delta_r_match_select_core.sv
// Testbench for the nearest delta-R match selector: random lists against a predicted best match
`default_nettype none

module tb_nearest_delta_r_match_select_core;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ndrm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]                      s_tuser = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ndrm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ndrm_pkg::CUT_W-1:0]      cfg_data = '0;

	nearest_delta_r_match_select_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	ndrm_pkg::cand_t   pending_cands[$];
	ndrm_pkg::result_t due_results[$];
	ndrm_pkg::cand_t   on_bus;
	int      fail_count = 0;
	int      send_wait = 0;
	int      recv_wait = 0;
	int      send_calm = 0;
	int      recv_calm = 0;

	// predicted block state
	logic [ndrm_pkg::CUT_W-1:0]  cut_now = ndrm_pkg::CUT_RESET;
	logic [ndrm_pkg::DIST_W-1:0] near_d2 = ndrm_pkg::DIST_NONE;
	int                          near_pos = 0;
	int                          list_pos = 0;
	bit                          near_seen = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void track_candidate(ndrm_pkg::cand_t c);
		logic [ndrm_pkg::PHI_W-1:0] phi_diff;
		longint                     de, dp, d2, cut2;
		ndrm_pkg::result_t          r;
		if (list_pos < ndrm_pkg::MAX_CANDIDATES) begin
			if (c.is_combined) begin
				phi_diff = c.muon_phi - c.probe_phi;
				de = longint'($signed(c.muon_eta)) - longint'($signed(c.probe_eta));
				dp = longint'($signed(phi_diff));
				d2 = de * de + dp * dp;
				// strict compare: an equal later distance keeps the earlier candidate
				if (d2 < longint'(near_d2)) begin
					near_d2 = ndrm_pkg::DIST_W'(d2);
					near_pos = list_pos;
					near_seen = 1'b1;
				end
			end
			list_pos++;
		end
		if (c.last_candidate) begin
			cut2 = longint'(cut_now) * longint'(cut_now);
			r.accepted = near_seen && (longint'(near_d2) <= cut2);
			r.match_found = near_seen;
			r.best_index = near_seen ? ndrm_pkg::IDX_W'(near_pos) : '0;
			r.best_distance_sq = near_seen ? near_d2 : ndrm_pkg::DIST_NONE;
			due_results.push_back(r);
			near_d2 = ndrm_pkg::DIST_NONE;
			near_pos = 0;
			list_pos = 0;
			near_seen = 1'b0;
		end
	endfunction

	function automatic void check_field(string what, longint want, longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones, now and then a calm stretch
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 3) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 120)
			return 0;
		if (r < 180)
			return $urandom_range(1, 3);
		if (r < 195)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic ndrm_pkg::cand_t mk(int pe, int pp, int me, int mp, bit comb, bit last);
		ndrm_pkg::cand_t c;
		c.probe_eta = ndrm_pkg::ETA_W'(pe);
		c.probe_phi = ndrm_pkg::PHI_W'(pp);
		c.muon_eta = ndrm_pkg::ETA_W'(me);
		c.muon_phi = ndrm_pkg::PHI_W'(mp);
		c.is_combined = comb;
		c.last_candidate = last;
		return c;
	endfunction

	function automatic int nudge(int spread);
		int off;
		off = $urandom_range(0, 2 * spread);
		return off - spread;
	endfunction

	// driver: one request per accepted candidate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready)
				track_candidate(on_bus);
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_cands.size() != 0) begin
					on_bus = pending_cands.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= ndrm_pkg::IN_DATA_W'({on_bus.muon_phi, on_bus.muon_eta,
						on_bus.probe_phi, on_bus.probe_eta});
					s_tuser <= on_bus.is_combined;
					s_tlast <= on_bus.last_candidate;
					send_wait = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result request against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		ndrm_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					want = due_results.pop_front();
					check_field("accepted", want.accepted, m_tdata[0]);
					check_field("match_found", want.match_found, m_tdata[1]);
					check_field("best_index", want.best_index, m_tdata[7:2]);
					check_field("best_distance_sq", want.best_distance_sq, m_tdata[42:8]);
				end
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_wait = pick_gap(recv_calm);
			end
		end
	end

	task automatic write_cut(input logic [ndrm_pkg::CUT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cut_now = value;
	endtask

	// wait for every prediction to be met, then let the pipeline settle
	task automatic drain();
		while (pending_cands.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_directed();
		pending_cands.push_back(mk(0, 0, 0, 0, 0, 1));                // empty list
		pending_cands.push_back(mk(0, 0, 100, 0, 1, 1));              // exactly on the cut
		pending_cands.push_back(mk(0, 0, 0, 101, 1, 1));              // just outside
		pending_cands.push_back(mk(-65536, 0, 65535, 0, 1, 1));       // widest eta gap
		pending_cands.push_back(mk(65535, -32768, -65536, -32768, 1, 1));
		pending_cands.push_back(mk(0, 32767, 0, -32768, 1, 1));       // phi wraps to one unit
		pending_cands.push_back(mk(0, 0, 0, -32768, 1, 1));           // half turn
		pending_cands.push_back(mk(-1, -1, -1, -1, 1, 1));            // zero distance
		// tie keeps the first, then a closer one wins, closed by a non-combined item
		pending_cands.push_back(mk(10, 20, 10, 20, 0, 0));
		pending_cands.push_back(mk(10, 20, 13, 24, 1, 0));
		pending_cands.push_back(mk(10, 20, 14, 23, 1, 0));
		pending_cands.push_back(mk(10, 20, 11, 20, 1, 0));
		pending_cands.push_back(mk(10, 20, 10, 20, 0, 1));
		// no combined candidate at all
		pending_cands.push_back(mk(5, 5, 5, 5, 0, 0));
		pending_cands.push_back(mk(5, 5, 5, 5, 0, 1));
		// probe values change within a list
		pending_cands.push_back(mk(1000, -2000, 1000, -1950, 1, 0));
		pending_cands.push_back(mk(-3000, 100, -2970, 100, 1, 1));
	endtask

	task automatic add_lists(int n_items);
		int                         sent, len, r, spread;
		bit                         steady, on_cut;
		logic [ndrm_pkg::ETA_W-1:0] pe;
		logic [ndrm_pkg::PHI_W-1:0] pp;
		ndrm_pkg::cand_t            c, prev;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// loose item with a random closing flag
				c.probe_eta = ndrm_pkg::ETA_W'($urandom);
				c.probe_phi = ndrm_pkg::PHI_W'($urandom);
				c.muon_eta = ndrm_pkg::ETA_W'($urandom);
				c.muon_phi = ndrm_pkg::PHI_W'($urandom);
				c.is_combined = 1'($urandom_range(0, 1));
				c.last_candidate = ($urandom_range(0, 3) == 0);
				pending_cands.push_back(c);
				sent++;
			end else if (r < 9) begin
				pending_cands.push_back(mk($urandom, $urandom, $urandom, $urandom, 0, 1));
				sent++;
			end else begin
				len = (r < 12) ? $urandom_range(63, 72) : $urandom_range(1, 8);
				steady = ($urandom_range(0, 15) != 0);
				case ($urandom_range(0, 5))
					0: spread = 0;
					1: spread = 3;
					2: spread = 40;
					3: spread = (cut_now > 65535) ? 65535 : int'(cut_now);
					4: spread = 2000;
					default: spread = 131071;
				endcase
				pe = ndrm_pkg::ETA_W'($urandom);
				pp = ndrm_pkg::PHI_W'($urandom);
				for (int i = 0; i < len; i++) begin
					c.probe_eta = steady ? pe : ndrm_pkg::ETA_W'($urandom);
					c.probe_phi = steady ? pp : ndrm_pkg::PHI_W'($urandom);
					on_cut = ($urandom_range(0, 7) == 0) && (cut_now <= 131071);
					if (on_cut) begin
						c.muon_eta = $urandom_range(0, 1)
							? c.probe_eta + ndrm_pkg::ETA_W'(cut_now)
							: c.probe_eta - ndrm_pkg::ETA_W'(cut_now);
						c.muon_phi = c.probe_phi;
					end else if (i > 0 && $urandom_range(0, 7) == 0) begin
						c.muon_eta = prev.muon_eta;
						c.muon_phi = prev.muon_phi;
					end else begin
						c.muon_eta = c.probe_eta + ndrm_pkg::ETA_W'(nudge(spread));
						c.muon_phi = c.probe_phi + ndrm_pkg::PHI_W'(nudge(spread));
					end
					c.is_combined = ($urandom_range(0, 3) != 0);
					c.last_candidate = (i == len - 1);
					pending_cands.push_back(c);
					prev = c;
					sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [ndrm_pkg::CUT_W-1:0] cut);
		write_cut(cut);
		add_lists(120);
		drain();
		add_lists(120);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cut(18'd100);
		add_directed();
		drain();
		run_phase('0);
		run_phase('1);
		run_phase(ndrm_pkg::CUT_W'($urandom_range(1, 4095)));
		run_phase(ndrm_pkg::CUT_W'($urandom_range(0, 262143)));
		run_phase(ndrm_pkg::CUT_W'(1));
		run_phase(ndrm_pkg::CUT_W'(131071));
		run_phase(ndrm_pkg::CUT_W'($urandom_range(0, 262143)));
		if (fail_count == 0 && due_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
